>>> rtl/rc4_pkg.sv
// rc4_pkg: shared types, sequencer step codes and the microcode table
// for the rc4 stream cipher core; no dependencies
package rc4_pkg;

    localparam int STEP_W = 4;
    typedef logic [STEP_W-1:0] t_step;

    // sequencer step addresses
    localparam t_step U_IDLE  = 4'd0;
    localparam t_step U_D1    = 4'd1;
    localparam t_step U_D2    = 4'd2;
    localparam t_step U_D3    = 4'd3;
    localparam t_step U_SINIT = 4'd4;
    localparam t_step U_S1    = 4'd5;
    localparam t_step U_S2    = 4'd6;
    localparam t_step U_S3    = 4'd7;
    localparam t_step U_S4    = 4'd8;
    localparam t_step U_FIN   = 4'd9;

    localparam logic [7:0] LAST_ROUND = 8'd255;

    // table read address source
    typedef enum logic [2:0] {
        RS_NONE,
        RS_A_INC,
        RS_J_SUM,
        RS_T_SUM,
        RS_SCH_I,
        RS_SCH_J,
        RS_SCH_INEXT
    } t_rsel;

    // table write source
    typedef enum logic [1:0] {
        WS_NONE,
        WS_A_SJ,
        WS_J_SA,
        WS_I_RD
    } t_wsel;

    // register load action
    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_D1,
        ACT_D2,
        ACT_OUT,
        ACT_SINIT,
        ACT_S2,
        ACT_S4,
        ACT_FIN
    } t_act;

    // next step selection
    typedef enum logic [2:0] {
        JMP_NEXT,
        JMP_DISPATCH,
        JMP_OUTWAIT,
        JMP_ALWAYS,
        JMP_LOOP
    } t_jmp;

    typedef struct packed {
        t_rsel rsel;
        t_wsel wsel;
        t_act  act;
        t_jmp  jmp;
        t_step target;
    } t_uword;

    // request from sequencer datapath to the permutation table
    typedef struct packed {
        logic       clr;
        logic       rd_en;
        logic [7:0] rd_addr;
        logic       wr_en;
        logic [7:0] wr_addr;
        logic [7:0] wr_data;
    } t_sbox_req;

    function automatic t_uword urom(input t_step step);
        t_uword w;
        case (step)
            U_IDLE:  w = '{RS_A_INC,     WS_NONE, ACT_NONE,  JMP_DISPATCH, U_IDLE};
            U_D1:    w = '{RS_J_SUM,     WS_NONE, ACT_D1,    JMP_NEXT,     U_IDLE};
            U_D2:    w = '{RS_T_SUM,     WS_A_SJ, ACT_D2,    JMP_NEXT,     U_IDLE};
            U_D3:    w = '{RS_NONE,      WS_J_SA, ACT_OUT,   JMP_OUTWAIT,  U_IDLE};
            U_SINIT: w = '{RS_NONE,      WS_NONE, ACT_SINIT, JMP_NEXT,     U_IDLE};
            U_S1:    w = '{RS_SCH_I,     WS_NONE, ACT_NONE,  JMP_NEXT,     U_IDLE};
            U_S2:    w = '{RS_SCH_J,     WS_NONE, ACT_S2,    JMP_NEXT,     U_IDLE};
            U_S3:    w = '{RS_NONE,      WS_I_RD, ACT_NONE,  JMP_NEXT,     U_IDLE};
            U_S4:    w = '{RS_SCH_INEXT, WS_J_SA, ACT_S4,    JMP_LOOP,     U_S2};
            U_FIN:   w = '{RS_NONE,      WS_NONE, ACT_FIN,   JMP_ALWAYS,   U_IDLE};
            default: w = '{RS_NONE,      WS_NONE, ACT_NONE,  JMP_ALWAYS,   U_IDLE};
        endcase
        return w;
    endfunction

endpackage

>>> rtl/rc4_keyed_stream_cipher_core.sv
// rc4_keyed_stream_cipher_core: top level, microcoded sequencer, key store
// and datapath; depends on rc4_pkg and rc4_sbox
//
// Input channel (i_in_valid / o_in_stall) carries one beat per byte: i_op low
// is a key byte, i_op high a data byte to cipher. A key byte with i_last high
// ends the key. Output channel (o_out_valid / i_out_stall) gives one beat per
// data byte: o_out_byte = data byte xor keystream byte.
// Key bytes are taken one per cycle; bytes past KEY_MAX are dropped, but a
// last mark on them still ends the key.
// A data byte runs through the accept step and three sequencer steps (D1, D2,
// D3), bound by the permutation table port: one read and one write per cycle.
// The result is registered in step D3.
// The last key byte starts the key schedule: o_in_stall stays high through setup
// (SINIT, S1), 256 rounds of three steps (S2, S3, S4) and wrap-up (FIN).
// While a result waits under i_out_stall the next byte is still accepted;
// the sequencer holds on its final step only if the output register is full and stalled.
// After reset the table is the identity, both indices are zero and the
// block is ready at once.
module rc4_keyed_stream_cipher_core #(
    parameter int KEY_MAX = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic       i_op,
    input  logic [7:0] i_value,
    input  logic       i_last,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte
);

    localparam int KW = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
    localparam int LW = $clog2(KEY_MAX + 1);

    rc4_pkg::t_step     r_upc, n_upc;
    rc4_pkg::t_uword    w_uw;
    rc4_pkg::t_sbox_req w_req;

    logic [7:0]    r_a, n_a;
    logic [7:0]    r_j, n_j;
    logic [7:0]    r_i, n_i;
    logic [7:0]    r_sa, n_sa;
    logic [7:0]    r_t, n_t;
    logic [7:0]    r_value, n_value;
    logic [7:0]    r_out, n_out;
    logic          r_out_vld, n_out_vld;
    logic [KW-1:0] r_kp, n_kp;
    logic [LW-1:0] r_klen, n_klen;
    logic [7:0]    r_key [KEY_MAX];
    logic [7:0]    r_kdata;

    logic [7:0]    w_rd;
    logic [KW-1:0] w_kp_next;
    logic          w_in_acc;
    logic          w_key_room;
    logic          w_go;

    assign w_uw       = rc4_pkg::urom(r_upc);
    assign o_in_stall = (r_upc != rc4_pkg::U_IDLE);
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_key_room = (r_klen < LW'(KEY_MAX));
    assign w_go       = (w_uw.jmp != rc4_pkg::JMP_OUTWAIT) || !r_out_vld || !i_out_stall;
    assign w_kp_next  = ((LW'(r_kp) + LW'(1)) >= r_klen) ? '0 : r_kp + KW'(1);

    rc4_sbox u_sbox (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (w_req),
        .o_rd_data (w_rd)
    );

    // table port requests from the current control word
    always_comb begin
        w_req         = '0;
        w_req.clr     = (w_uw.act == rc4_pkg::ACT_SINIT);
        w_req.rd_en   = (w_uw.rsel != rc4_pkg::RS_NONE);
        case (w_uw.rsel)
            rc4_pkg::RS_A_INC:     w_req.rd_addr = r_a + 8'd1;
            rc4_pkg::RS_J_SUM:     w_req.rd_addr = r_j + w_rd;
            rc4_pkg::RS_T_SUM:     w_req.rd_addr = r_sa + w_rd;
            rc4_pkg::RS_SCH_I:     w_req.rd_addr = r_i;
            rc4_pkg::RS_SCH_J:     w_req.rd_addr = r_j + w_rd + r_kdata;
            rc4_pkg::RS_SCH_INEXT: w_req.rd_addr = r_i + 8'd1;
            default:               w_req.rd_addr = r_i;
        endcase
        w_req.wr_en = (w_uw.wsel != rc4_pkg::WS_NONE) && w_go;
        case (w_uw.wsel)
            rc4_pkg::WS_A_SJ: begin
                w_req.wr_addr = r_a;
                w_req.wr_data = w_rd;
            end
            rc4_pkg::WS_J_SA: begin
                w_req.wr_addr = r_j;
                w_req.wr_data = r_sa;
            end
            rc4_pkg::WS_I_RD: begin
                w_req.wr_addr = r_i;
                w_req.wr_data = w_rd;
            end
            default: begin
                w_req.wr_addr = r_i;
                w_req.wr_data = w_rd;
            end
        endcase
    end

    // step counter and register loads
    always_comb begin
        n_upc     = r_upc;
        n_a       = r_a;
        n_j       = r_j;
        n_i       = r_i;
        n_sa      = r_sa;
        n_t       = r_t;
        n_value   = r_value;
        n_out     = r_out;
        n_out_vld = r_out_vld && i_out_stall;
        n_kp      = r_kp;
        n_klen    = r_klen;

        case (w_uw.jmp)
            rc4_pkg::JMP_NEXT: n_upc = r_upc + rc4_pkg::t_step'(1);
            rc4_pkg::JMP_DISPATCH: begin
                if (w_in_acc && i_op) begin
                    n_upc = rc4_pkg::U_D1;
                end else if (w_in_acc && i_last) begin
                    n_upc = rc4_pkg::U_SINIT;
                end else begin
                    n_upc = rc4_pkg::U_IDLE;
                end
            end
            rc4_pkg::JMP_OUTWAIT: n_upc = w_go ? w_uw.target : r_upc;
            rc4_pkg::JMP_ALWAYS:  n_upc = w_uw.target;
            rc4_pkg::JMP_LOOP: begin
                n_upc = (r_i == rc4_pkg::LAST_ROUND) ? r_upc + rc4_pkg::t_step'(1)
                                                     : w_uw.target;
            end
            default: n_upc = rc4_pkg::U_IDLE;
        endcase

        if (w_in_acc) begin
            if (i_op) begin
                n_a     = r_a + 8'd1;
                n_value = i_value;
            end else if (w_key_room) begin
                n_klen = r_klen + LW'(1);
            end
        end

        case (w_uw.act)
            rc4_pkg::ACT_D1: begin
                n_sa = w_rd;
                n_j  = r_j + w_rd;
            end
            rc4_pkg::ACT_D2: n_t = r_sa + w_rd;
            rc4_pkg::ACT_OUT: begin
                // the j write lands after the read of t, so forward it here
                if (w_go) begin
                    n_out_vld = 1'b1;
                    n_out     = r_value ^ ((r_t == r_j) ? r_sa : w_rd);
                end
            end
            rc4_pkg::ACT_SINIT: begin
                n_i  = 8'd0;
                n_j  = 8'd0;
                n_kp = '0;
            end
            rc4_pkg::ACT_S2: begin
                n_sa = w_rd;
                n_j  = r_j + w_rd + r_kdata;
            end
            rc4_pkg::ACT_S4: begin
                n_i  = r_i + 8'd1;
                n_kp = w_kp_next;
            end
            rc4_pkg::ACT_FIN: begin
                n_a    = 8'd0;
                n_j    = 8'd0;
                n_klen = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc     <= rc4_pkg::U_IDLE;
            r_a       <= 8'd0;
            r_j       <= 8'd0;
            r_klen    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_upc     <= n_upc;
            r_a       <= n_a;
            r_j       <= n_j;
            r_klen    <= n_klen;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i     <= n_i;
        r_sa    <= n_sa;
        r_t     <= n_t;
        r_value <= n_value;
        r_out   <= n_out;
        r_kp    <= n_kp;
    end

    // key store: written on key beats, read one entry ahead of each round
    always_ff @(posedge i_clk) begin
        if (w_in_acc && !i_op && w_key_room) begin
            r_key[r_klen[KW-1:0]] <= i_value;
        end
        if (w_uw.rsel == rc4_pkg::RS_SCH_I) begin
            r_kdata <= r_key[r_kp];
        end else if (w_uw.rsel == rc4_pkg::RS_SCH_INEXT) begin
            r_kdata <= r_key[w_kp_next];
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_byte  = r_out;

endmodule

>>> rtl/rc4_sbox.sv
// rc4_sbox: 256 x 8 permutation table, one read and one write per cycle,
// registered read with write-first bypass; depends on rc4_pkg
module rc4_sbox (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rc4_pkg::t_sbox_req i_req,
    output logic [7:0]         o_rd_data
);

    logic [7:0] r_mem [256];
    logic [255:0] r_vld;
    logic [7:0] r_rd_data;
    logic [7:0] r_rd_addr;
    logic       r_rd_vld;
    logic       w_byp;

    assign w_byp = i_req.wr_en && (i_req.wr_addr == i_req.rd_addr);

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= w_byp ? i_req.wr_data : r_mem[i_req.rd_addr];
            r_rd_addr <= i_req.rd_addr;
        end
    end

    // entries not yet written since the last clear read as their own index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_req.clr) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_req.wr_en) begin
                r_vld[i_req.wr_addr] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rd_vld <= w_byp | r_vld[i_req.rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : r_rd_addr;

endmodule

>>> rtl/rc4_chk.sv
// rc4_chk: port-level assertions for rc4_keyed_stream_cipher_core and the
// bind that attaches them; depends on the top level's ports only
module rc4_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic       i_op,
    input logic [7:0] i_value,
    input logic       i_last,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [7:0] o_out_byte
);

    logic w_in_acc;
    assign w_in_acc = i_in_valid && !o_in_stall;

    // a data beat always occupies the sequencer for the following cycles
    a_data_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && i_op |=> o_in_stall ##1 o_in_stall ##1 o_in_stall)
        else $error("data beat did not hold the input stalled");

    // a key byte that does not end the key leaves the block ready
    a_key_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && !i_op && !i_last |=> !o_in_stall)
        else $error("plain key byte stalled the input");

    // the ending key byte starts the schedule
    a_sched_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && !i_op && i_last |=> o_in_stall ##1 o_in_stall)
        else $error("key schedule did not start");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_byte))
        else $error("stalled output beat changed");

endmodule

bind rc4_keyed_stream_cipher_core rc4_chk u_rc4_chk (.*);
